// ===== rtl/ansi_sgr_color_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// ansi sgr color parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ANSI_SGR_COLOR_PARSER_TOP_DEFINES_SVH
`define ANSI_SGR_COLOR_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ASGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("asgr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("asgr assertion failed");

`endif

// ===== rtl/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// asgr_pkg
// Types, character codes and the sgr code evaluation shared by the parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [8:0] style_index;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_CSI  = 3'b100
    } t_mode;

    typedef enum logic [3:0] {
        TOK_EMPTY = 4'b0001,
        TOK_WS    = 4'b0010,
        TOK_NUM   = 4'b0100,
        TOK_END   = 4'b1000
    } t_tphase;

    typedef enum logic [2:0] {
        EXT_NONE = 3'b001,
        EXT_38   = 3'b010,
        EXT_38_5 = 3'b100
    } t_xphase;

    typedef struct packed {
        t_mode      parse_mode;
        logic [8:0] committed_style;
        logic [8:0] pending_style;
        logic [8:0] token_magnitude;
        logic       token_negative;
        t_tphase    token_phase;
        t_xphase    extended_color_phase;
        logic       any_token_done;
    } t_state;

    typedef struct packed {
        logic [8:0] pending_style;
        t_xphase    extended_color_phase;
    } t_apply;

    localparam t_state STATE_RESET = '{
        parse_mode:           MODE_TEXT,
        committed_style:      9'd0,
        pending_style:        9'd0,
        token_magnitude:      9'd0,
        token_negative:       1'b0,
        token_phase:          TOK_EMPTY,
        extended_color_phase: EXT_NONE,
        any_token_done:       1'b0
    };

    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_M      = 8'h6D;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    localparam logic [8:0]  MAG_MAX     = 9'd511;
    localparam logic [8:0]  SGR_FG_LO   = 9'd30;
    localparam logic [8:0]  SGR_FG_HI   = 9'd37;
    localparam logic [8:0]  SGR_BRT_LO  = 9'd90;
    localparam logic [8:0]  SGR_BRT_HI  = 9'd97;
    localparam logic [8:0]  SGR_EXT     = 9'd38;
    localparam logic [8:0]  SGR_EXT_256 = 9'd5;
    localparam logic [8:0]  COLOR_MAX   = 9'd255;
    localparam logic [8:0]  STYLE_BASE  = 9'd4;
    localparam logic [8:0]  STYLE_MAX   = 9'd259;

    // evaluate one finished sgr parameter against the tentative style
    function automatic t_apply f_apply_code(logic [8:0] mag, logic neg,
                                            logic [8:0] pend, t_xphase xp);
        t_apply r;
        logic   nonneg;
        logic   done;
        r.pending_style        = pend;
        r.extended_color_phase = xp;
        nonneg = !neg || (mag == 9'd0);
        done   = 1'b0;
        if (xp == EXT_38_5) begin
            if (nonneg && (mag <= COLOR_MAX)) begin
                r.pending_style = STYLE_BASE + mag;
            end
            r.extended_color_phase = EXT_NONE;
            done = 1'b1;
        end else if (xp == EXT_38) begin
            r.extended_color_phase = EXT_NONE;
            if (nonneg && (mag == SGR_EXT_256)) begin
                r.extended_color_phase = EXT_38_5;
                done = 1'b1;
            end
        end
        if (!done) begin
            priority if (mag == 9'd0) begin
                r.pending_style = 9'd0;
            end else if (nonneg) begin
                priority if ((mag >= SGR_FG_LO) && (mag <= SGR_FG_HI)) begin
                    r.pending_style = mag - (SGR_FG_LO - STYLE_BASE);
                end else if ((mag >= SGR_BRT_LO) && (mag <= SGR_BRT_HI)) begin
                    r.pending_style = mag - (SGR_BRT_LO - STYLE_BASE - 9'd8);
                end else if (mag == SGR_EXT) begin
                    r.extended_color_phase = EXT_38;
                end else begin
                    // other codes leave the style alone
                end
            end else begin
                // negative codes are ignored
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/asgr_step.sv =====
// ----------------------------------------------------------------------------
// asgr_step
// Next-state and result logic for one input byte of the sgr parser.
// ----------------------------------------------------------------------------
module asgr_step
    import asgr_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_res0,
    output t_out_item o_res1,
    output logic [1:0] o_nres
);

    t_state      s;
    t_apply      ap;
    logic [7:0]  b;
    logic        esc_out;
    logic        emit_b;
    logic [8:0]  esc_style;
    logic        is_letter;
    logic        is_ws;
    logic        is_dig;
    logic [8:0]  dig_val;
    logic [12:0] acc;

    assign b         = i_item.data_byte;
    assign is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    assign is_ws     = (b == CHR_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    assign is_dig    = (b >= CHR_ZERO) && (b <= CHR_NINE);
    // low nibble of an ascii digit is its value
    assign dig_val   = {5'd0, b[3:0]};
    assign acc       = {i_state.token_magnitude, 3'b000}
                     + {3'b000, i_state.token_magnitude, 1'b0}
                     + {4'd0, dig_val};
    assign esc_out   = (i_state.parse_mode == MODE_ESC)
                     && (i_item.chunk_start || (b != CHR_LBRACK));
    assign esc_style = i_state.committed_style;
    assign ap        = f_apply_code(i_state.token_magnitude, i_state.token_negative,
                                    i_state.pending_style, i_state.extended_color_phase);

    always_comb begin
        s      = i_state;
        emit_b = 1'b0;
        if (esc_out) begin
            s.parse_mode = MODE_TEXT;
        end
        // chunk reset lands after a held esc is released
        if (i_item.chunk_start) begin
            s = STATE_RESET;
        end
        unique case (s.parse_mode)
            MODE_TEXT: begin
                if (b == CHR_ESC) begin
                    s.parse_mode = MODE_ESC;
                end else begin
                    emit_b = 1'b1;
                end
            end
            MODE_ESC: begin
                s.parse_mode           = MODE_CSI;
                s.pending_style        = s.committed_style;
                s.token_magnitude      = 9'd0;
                s.token_negative       = 1'b0;
                s.token_phase          = TOK_EMPTY;
                s.extended_color_phase = EXT_NONE;
                s.any_token_done       = 1'b0;
            end
            MODE_CSI: begin
                priority if (is_letter) begin
                    if (b == CHR_M) begin
                        // trailing empty parameter after a ';' is dropped
                        if (!((s.token_phase == TOK_EMPTY) && s.any_token_done)) begin
                            s.committed_style = ap.pending_style;
                        end else begin
                            s.committed_style = s.pending_style;
                        end
                    end
                    s.parse_mode           = MODE_TEXT;
                    s.token_magnitude      = 9'd0;
                    s.token_negative       = 1'b0;
                    s.token_phase          = TOK_EMPTY;
                    s.extended_color_phase = EXT_NONE;
                    s.any_token_done       = 1'b0;
                end else if (b == CHR_SEMI) begin
                    s.pending_style        = ap.pending_style;
                    s.extended_color_phase = ap.extended_color_phase;
                    s.any_token_done       = 1'b1;
                    s.token_magnitude      = 9'd0;
                    s.token_negative       = 1'b0;
                    s.token_phase          = TOK_EMPTY;
                end else begin
                    unique case (s.token_phase)
                        TOK_EMPTY, TOK_WS: begin
                            priority if (is_ws) begin
                                s.token_phase = TOK_WS;
                            end else if ((b == CHR_PLUS) || (b == CHR_MINUS)) begin
                                s.token_negative = (b == CHR_MINUS);
                                s.token_phase    = TOK_NUM;
                            end else if (is_dig) begin
                                s.token_magnitude = dig_val;
                                s.token_phase     = TOK_NUM;
                            end else begin
                                s.token_phase = TOK_END;
                            end
                        end
                        TOK_NUM: begin
                            if (is_dig) begin
                                s.token_magnitude = (acc > {4'd0, MAG_MAX}) ? MAG_MAX
                                                                            : acc[8:0];
                            end else begin
                                s.token_phase = TOK_END;
                            end
                        end
                        TOK_END: begin
                        end
                        default: begin
                            s.token_phase = TOK_END;
                        end
                    endcase
                end
            end
            default: begin
                s = STATE_RESET;
            end
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_res1.out_byte    = b;
        o_res1.style_index = s.committed_style;
        o_res1.last_of_run = 1'b1;
        if (esc_out) begin
            o_res0.out_byte    = CHR_ESC;
            o_res0.style_index = esc_style;
            o_res0.last_of_run = !emit_b;
        end else begin
            o_res0 = o_res1;
        end
    end

    assign o_nres = {1'b0, esc_out} + {1'b0, emit_b};

endmodule

// ===== rtl/ansi_sgr_color_parser_top.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser_top
// Strips ansi csi escape sequences from a byte stream and tags text bytes
// with the committed sgr color style.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the output does not stall. A byte is
// registered into s1 on transfer and evaluated once the result buffer
// drains; its results are registered in the result buffer and offered from
// there. A byte that releases a held esc together with itself yields two
// results; the single result port offers them one by one and the input
// stalls meanwhile. Other bytes yield one result or none.
`include "ansi_sgr_color_parser_top_defines.svh"

module ansi_sgr_color_parser_top
    import asgr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic       r_s1_valid;
    t_in_item   r_s1_item;
    t_state     r_state;
    t_state     n_state;
    t_out_item  r_buf [2];
    logic [1:0] r_cnt;
    t_out_item  step_res0;
    t_out_item  step_res1;
    logic [1:0] step_nres;
    logic       pop;
    logic       s1_take;
    logic       in_xfer;

    asgr_step u_step (
        .i_state (r_state),
        .i_item  (r_s1_item),
        .o_state (n_state),
        .o_res0  (step_res0),
        .o_res1  (step_res1),
        .o_nres  (step_nres)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_buf[0];
    assign pop         = o_out_valid && !i_out_stall;
    // evaluate only when the result buffer drains this cycle
    assign s1_take     = r_s1_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign o_in_stall  = r_s1_valid && !s1_take;
    assign in_xfer     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (s1_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (s1_take) begin
            r_cnt <= step_nres;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_buf[0] <= step_res0;
            r_buf[1] <= step_res1;
        end else if (pop) begin
            r_buf[0] <= r_buf[1];
        end
    end

    `ASGR_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, r_cnt == 2'd2, !r_buf[0].last_of_run)
    `ASGR_ASSERT_NOW(a_style_range, i_clk, i_rst_n, o_out_valid,
                     o_out_data.style_index <= STYLE_MAX)
    `ASGR_ASSERT_NEXT(a_style_hold, i_clk, i_rst_n, !s1_take,
                      $stable(r_state.committed_style))
    `ASGR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
                     r_s1_valid && (r_cnt != 2'd0))

endmodule

// ===== verif/tb_ansi_sgr_color_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ansi_sgr_color_parser_top
// Feeds byte streams with csi/sgr sequences, text and noise into the parser
// and checks every text transfer against a cycle-free model of the stripper.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_color_parser_top;
    import asgr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_BYTES = 750;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic [7:0] CHR_TAB  = 8'h09;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_UC_A = 8'h41;
    localparam logic [7:0] CHR_UC_Z = 8'h5A;
    localparam logic [7:0] CHR_LC_A = 8'h61;
    localparam logic [7:0] CHR_LC_Z = 8'h7A;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          drain;
    } t_feed;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    t_feed       byte_feed[$];
    t_out_item   text_expected[$];
    int unsigned byte_feed_total = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned text_checked    = 0;
    int unsigned palette_hits    = 0;
    int unsigned chunk_cnt       = 0;
    int unsigned commit_cnt      = 0;
    int unsigned err_cnt         = 0;
    int unsigned cycle_cnt       = 0;
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;
    logic        in_took         = 1'b0;
    logic        out_took        = 1'b0;

    // model state
    t_mode      pm         = MODE_TEXT;
    logic [8:0] style_cur  = '0;
    logic [8:0] style_tent = '0;
    logic [8:0] tok_mag    = '0;
    logic       tok_neg    = 1'b0;
    t_tphase    tok_ph     = TOK_EMPTY;
    t_xphase    ext_ph     = EXT_NONE;
    logic       sep_seen   = 1'b0;

    ansi_sgr_color_parser_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CHR_UC_A) && (c <= CHR_UC_Z)) || ((c >= CHR_LC_A) && (c <= CHR_LC_Z));
    endfunction

    task automatic token_restart();
        tok_mag = '0;
        tok_neg = 1'b0;
        tok_ph  = TOK_EMPTY;
    endtask

    // one finished parameter against the tentative style
    task automatic sgr_apply(input logic [8:0] mag, input logic neg);
        logic pos;
        pos = !neg || (mag == 9'd0);
        if (ext_ph == EXT_38_5) begin
            if (pos && (mag <= COLOR_MAX)) begin
                style_tent = STYLE_BASE + mag;
            end
            ext_ph = EXT_NONE;
        end else if ((ext_ph == EXT_38) && pos && (mag == SGR_EXT_256)) begin
            ext_ph = EXT_38_5;
        end else begin
            ext_ph = EXT_NONE;
            if (mag == 9'd0) begin
                style_tent = '0;
            end else if (pos) begin
                if ((mag >= SGR_FG_LO) && (mag <= SGR_FG_HI)) begin
                    style_tent = STYLE_BASE + (mag - SGR_FG_LO);
                end else if ((mag >= SGR_BRT_LO) && (mag <= SGR_BRT_HI)) begin
                    style_tent = STYLE_BASE + 9'd8 + (mag - SGR_BRT_LO);
                end else if (mag == SGR_EXT) begin
                    ext_ph = EXT_38;
                end
            end
        end
    endtask

    // strips one byte and queues the text transfers it releases
    task automatic strip_and_tag(input t_in_item it);
        t_out_item  res [2];
        int         n;
        int         k;
        int         acc;
        logic [7:0] b;
        logic       ws;
        logic       dig;
        b = it.data_byte;
        n = 0;
        if ((pm == MODE_ESC) && (it.chunk_start || (b != CHR_LBRACK))) begin
            res[n] = '{out_byte: CHR_ESC, style_index: style_cur, last_of_run: 1'b0};
            n++;
            pm = MODE_TEXT;
        end
        if (it.chunk_start) begin
            pm         = MODE_TEXT;
            style_cur  = '0;
            style_tent = '0;
            token_restart();
            ext_ph     = EXT_NONE;
            sep_seen   = 1'b0;
            chunk_cnt++;
        end
        case (pm)
            MODE_TEXT: begin
                if (b == CHR_ESC) begin
                    pm = MODE_ESC;
                end else begin
                    res[n] = '{out_byte: b, style_index: style_cur, last_of_run: 1'b0};
                    n++;
                end
            end
            MODE_ESC: begin
                pm         = MODE_CSI;
                style_tent = style_cur;
                token_restart();
                ext_ph     = EXT_NONE;
                sep_seen   = 1'b0;
            end
            default: begin
                if (is_letter(b)) begin
                    if (b == CHR_M) begin
                        // an empty token after the last separator is dropped
                        if (!((tok_ph == TOK_EMPTY) && sep_seen)) begin
                            sgr_apply(tok_mag, tok_neg);
                        end
                        style_cur = style_tent;
                        commit_cnt++;
                    end
                    pm = MODE_TEXT;
                    token_restart();
                    ext_ph   = EXT_NONE;
                    sep_seen = 1'b0;
                end else if (b == CHR_SEMI) begin
                    sgr_apply(tok_mag, tok_neg);
                    sep_seen = 1'b1;
                    token_restart();
                end else begin
                    ws  = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
                    dig = (b >= CHR_ZERO) && (b <= CHR_NINE);
                    if ((tok_ph == TOK_EMPTY) || (tok_ph == TOK_WS)) begin
                        if (ws) begin
                            tok_ph = TOK_WS;
                        end else if ((b == CHR_PLUS) || (b == CHR_MINUS)) begin
                            tok_neg = (b == CHR_MINUS);
                            tok_ph  = TOK_NUM;
                        end else if (dig) begin
                            tok_mag = b - CHR_ZERO;
                            tok_ph  = TOK_NUM;
                        end else begin
                            tok_ph = TOK_END;
                        end
                    end else if (tok_ph == TOK_NUM) begin
                        if (dig) begin
                            acc     = tok_mag * 10 + (b - CHR_ZERO);
                            tok_mag = (acc > MAG_MAX) ? MAG_MAX : acc[8:0];
                        end else begin
                            tok_ph = TOK_END;
                        end
                    end
                end
            end
        endcase
        if (n > 0) begin
            res[n-1].last_of_run = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            text_expected = {text_expected, res[k]};
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic start);
        t_feed f;
        f.item.data_byte   = b;
        f.item.chunk_start = start;
        // every third stretch runs back to back
        f.gap   = (((byte_feed_total / 90) % 3) == 1) ? 0 : $urandom_range(0, 4);
        f.drain = ((byte_feed_total % 150) == 149);
        byte_feed = {byte_feed, f};
        byte_feed_total++;
    endtask

    task automatic push_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            push_byte(s[k], 1'b0);
        end
    endtask

    task automatic push_token(input int unsigned val, input bit has_digits);
        int         r;
        logic [7:0] w;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                w = ($urandom_range(0, 2) == 0) ? CHR_SPACE : 8'($urandom_range(9, 13));
                push_byte(w, 1'b0);
            end
        end
        r = $urandom_range(0, 11);
        if (r == 0) begin
            push_byte(CHR_MINUS, 1'b0);
        end else if (r == 1) begin
            push_byte(CHR_PLUS, 1'b0);
        end
        if (has_digits) begin
            push_str($sformatf("%0d", val));
        end
        // trailing garbage ends the token without a separator
        if ($urandom_range(0, 9) == 0) begin
            do begin
                w = 8'($urandom);
            end while (is_letter(w) || (w == CHR_SEMI));
            push_byte(w, 1'b0);
        end
    endtask

    task automatic push_sequence();
        int         np;
        int         k;
        int         r;
        logic [7:0] w;
        push_byte(CHR_ESC, 1'b0);
        push_byte(CHR_LBRACK, 1'b0);
        np = $urandom_range(0, 4);
        for (k = 0; k < np; k++) begin
            if (k > 0) begin
                push_byte(CHR_SEMI, 1'b0);
            end
            r = $urandom_range(0, 9);
            case (r)
                0: push_token(0, 1'b0);
                1: push_token(0, 1'b1);
                2, 3: push_token($urandom_range(30, 37), 1'b1);
                4: push_token($urandom_range(90, 97), 1'b1);
                5: begin
                    push_token(SGR_EXT, 1'b1);
                    push_byte(CHR_SEMI, 1'b0);
                    push_token(SGR_EXT_256, 1'b1);
                    push_byte(CHR_SEMI, 1'b0);
                    push_token($urandom_range(0, 300), 1'b1);
                end
                6: push_token(SGR_EXT, 1'b1);
                7: push_token($urandom_range(0, 600), 1'b1);
                8: push_token($urandom_range(1000, 99999), 1'b1);
                default: push_token($urandom_range(0, 127), 1'b1);
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            push_byte(CHR_SEMI, 1'b0);
        end
        r = $urandom_range(0, 15);
        if (r < 12) begin
            push_byte(CHR_M, 1'b0);
        end else if (r < 14) begin
            do begin
                w = 8'($urandom);
            end while (!is_letter(w) || (w == CHR_M));
            push_byte(w, 1'b0);
        end else if (r == 14) begin
            // sequence cut off by a new chunk
            push_byte(8'($urandom_range(32, 126)), 1'b1);
        end
    endtask

    task automatic push_text();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 15) == 0) begin
                push_byte(CHR_ESC, 1'b0);
            end
            push_byte(8'($urandom), $urandom_range(0, 24) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge clk) begin : in_driver
        t_feed    nxt;
        logic     v;
        t_in_item d;
        v = in_valid;
        d = in_data;
        if (!rst_n) begin
            v = 1'b0;
        end else if (!in_valid || in_took) begin
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if ((byte_feed.size() > 0) &&
                         !(byte_feed[0].drain && (text_expected.size() != 0))) begin
                nxt      = byte_feed.pop_front();
                d        = nxt.item;
                v        = 1'b1;
                gap_left = nxt.gap;
            end
        end
        in_valid <= v;
        in_data  <= d;
    end

    // ------------------------------------------------------------------
    // output stall
    // ------------------------------------------------------------------
    always @(negedge clk) begin : out_throttle
        logic s;
        s = 1'b0;
        if (rst_n) begin
            if (out_took) begin
                stall_left = (((text_checked / 60) % 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            s = out_valid && (stall_left > 0);
            if (s) begin
                stall_left--;
            end
        end
        out_stall <= s;
    end

    // ------------------------------------------------------------------
    // transfer monitor and checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (!rst_n) begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end else begin
            in_took  <= in_valid && !in_stall;
            out_took <= out_valid && !out_stall;
            if (in_valid && !in_stall) begin
                strip_and_tag(in_data);
                bytes_accepted++;
            end
            if (out_valid && !out_stall) begin
                text_checked++;
                if (out_data.style_index > 9'd19) begin
                    palette_hits++;
                end
                if (text_expected.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("error: unexpected transfer byte %02h style %0d last %0b",
                                 out_data.out_byte, out_data.style_index,
                                 out_data.last_of_run);
                    end
                end else begin
                    want = text_expected.pop_front();
                    if ((out_data.out_byte !== want.out_byte) ||
                        (out_data.style_index !== want.style_index) ||
                        (out_data.last_of_run !== want.last_of_run)) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("error: transfer %0d exp byte %02h style %0d last %0b, %s",
                                     text_checked, want.out_byte, want.style_index,
                                     want.last_of_run,
                                     $sformatf("got byte %02h style %0d last %0b",
                                               out_data.out_byte, out_data.style_index,
                                               out_data.last_of_run));
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_flow
        int unsigned target;
        int          r;

        // directed: extremes, palette limit, empty list, lone esc, chunk cut
        push_byte(CHR_UC_A, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(CHR_ESC, 1'b0);
        push_str("[38;5;255m");
        push_byte(8'hFF, 1'b0);
        push_byte(CHR_ESC, 1'b0);
        push_str("[mq");
        push_byte(CHR_ESC, 1'b0);
        push_str("X");
        push_byte(CHR_ESC, 1'b0);
        push_byte(8'h42, 1'b1);
        push_byte(CHR_ESC, 1'b0);
        push_str("[9Hk");

        target = byte_feed_total + RANDOM_BYTES;
        while (byte_feed_total < target) begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    push_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
            end else begin
                push_sequence();
                push_text();
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted != byte_feed_total) begin
            @(posedge clk);
        end
        while (text_expected.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (text_expected.size() != 0) begin
            err_cnt += text_expected.size();
            $display("error: %0d text transfers never arrived", text_expected.size());
        end

        $display("covered %0d bytes in %0d chunks, %0d text transfers checked",
                 bytes_accepted, chunk_cnt, text_checked);
        $display("%0d sgr sequences committed, %0d transfers in 256-color styles, %0d errors",
                 commit_cnt, palette_hits, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
